FILE: hdl/trp_pkg.sv
// Shared types and flag constants for the track run box parser.
package trp_pkg;

    // Presence flags of the box.
    localparam logic [23:0] FLAG_OFFSET   = 24'h000001;
    localparam logic [23:0] FLAG_FIRST    = 24'h000004;
    localparam logic [23:0] FLAG_DURATION = 24'h000100;
    localparam logic [23:0] FLAG_SIZE     = 24'h000200;
    localparam logic [23:0] FLAG_SFLAGS   = 24'h000400;
    localparam logic [23:0] FLAG_CTO      = 24'h000800;
    localparam logic [23:0] FLAG_ANY_SAMPLE =
        FLAG_DURATION | FLAG_SIZE | FLAG_SFLAGS | FLAG_CTO;

    // Bit position of the duration flag; the other sample flags follow it.
    localparam int SAMPLE_FLAG_LSB = 8;

    // Record kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       box_start;
    } t_trp_in;

    typedef struct packed {
        logic               record_kind;
        logic [7:0]         box_version;
        logic [23:0]        box_flags;
        logic [31:0]        count_of_samples;
        logic signed [31:0] payload_offset;
        logic [31:0]        first_flags;
        logic [31:0]        duration;
        logic [31:0]        size_bytes;
        logic [31:0]        per_sample_flags;
        logic [31:0]        composition_offset;
        logic [31:0]        sample_number;
        logic               last_record;
    } t_trp_out;

endpackage

FILE: hdl/trp_out_buf.sv
// Two-entry output buffer that holds finished records while the consumer stalls.
module trp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trp_pkg::t_trp_out i_push_data,
    output logic              o_full,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output trp_pkg::t_trp_out o_out_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    trp_pkg::t_trp_out r_out_data;
    trp_pkg::t_trp_out r_skid_data;
    logic              pop;

    assign pop         = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= i_push;
                    if (i_push) begin
                        r_skid_data <= i_push_data;
                    end
                end else begin
                    r_out_valid <= i_push;
                    if (i_push) begin
                        r_out_data <= i_push_data;
                    end
                end
            end else if (i_push) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= i_push_data;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= i_push_data;
                end
            end
        end
    end

    // The spare entry is only used behind a full output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("spare entry filled while output entry empty");

    // A stalled record with a spare record behind it is still shown next cycle.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled record lost while buffer full");

endmodule

FILE: hdl/track_run_box_parser.sv
// Top level of the track run box parser: byte-wise field parsing and record assembly.
//
//   channel  direction  valid        stall        payload
//   input    in         i_in_valid   o_in_stall   i_in_data  (trp_pkg::t_trp_in)
//   output   out        o_out_valid  i_out_stall  o_out_data (trp_pkg::t_trp_out)
//
// One byte is accepted per clock while o_in_stall is low. A record caused by a byte
// is registered on the accepting edge and offered next cycle if no record waits ahead.
// Synchronous active-low reset puts the parser in the idle phase, waiting for a
// byte marked as box start, and empties the output buffer.
// Records queue in a two-entry output buffer; the input stalls only while both
// entries hold records.
module track_run_box_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  trp_pkg::t_trp_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output trp_pkg::t_trp_out o_out_data
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_COUNT,
        PH_OFFSET,
        PH_FIRST,
        PH_DUR,
        PH_SIZE,
        PH_SFLAGS,
        PH_CTO,
        PH_DONE
    } t_phase;

    // First present sample field with index at or above the start index, or four
    // when no such field is present.
    function automatic logic [2:0] next_field(input logic [23:0] flags,
                                              input logic [2:0]  from);
        logic [2:0] res;
        res = 3'd4;
        for (int j = 3; j >= 0; j--) begin
            if (3'(j) >= from && flags[trp_pkg::SAMPLE_FLAG_LSB + j]) begin
                res = 3'(j);
            end
        end
        return res;
    endfunction

    function automatic t_phase phase_of(input logic [2:0] idx);
        t_phase ph;
        case (idx)
            3'd0:    ph = PH_DUR;
            3'd1:    ph = PH_SIZE;
            3'd2:    ph = PH_SFLAGS;
            default: ph = PH_CTO;
        endcase
        return ph;
    endfunction

    // Parser state.
    t_phase      r_phase,   n_phase;
    logic [1:0]  r_pos,     n_pos;
    logic [23:0] r_shift,   n_shift;
    logic [7:0]  r_version, n_version;
    logic [23:0] r_flags,   n_flags;
    logic [31:0] r_count,   n_count;
    logic [31:0] r_offset,  n_offset;
    logic [31:0] r_first,   n_first;
    logic [31:0] r_store [3];
    logic [31:0] n_store [3];
    logic [31:0] r_seen,    n_seen;

    logic              accept;
    logic              buf_full;
    logic [7:0]        in_byte;
    logic [31:0]       word;
    logic [2:0]        k;
    logic [2:0]        nxt;
    logic              hdr_done;
    logic              smp_done;
    logic              rec_last;
    logic              res_valid;
    trp_pkg::t_trp_out res;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;
    assign in_byte    = i_in_data.byte_in;
    assign word       = {r_shift, in_byte};

    // Index of the sample field being collected in the current phase.
    always_comb begin
        case (r_phase)
            PH_DUR:    k = 3'd0;
            PH_SIZE:   k = 3'd1;
            PH_SFLAGS: k = 3'd2;
            default:   k = 3'd3;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_shift   = r_shift;
        n_version = r_version;
        n_flags   = r_flags;
        n_count   = r_count;
        n_offset  = r_offset;
        n_first   = r_first;
        n_store   = r_store;
        n_seen    = r_seen;
        hdr_done  = 1'b0;
        smp_done  = 1'b0;
        rec_last  = 1'b0;
        nxt       = 3'd4;

        if (accept) begin
            if (i_in_data.box_start) begin
                // A start byte abandons any box in progress.
                n_phase   = PH_FLAGS;
                n_pos     = 2'd0;
                n_shift   = '0;
                n_version = in_byte;
                n_flags   = '0;
                n_count   = '0;
                n_offset  = '0;
                n_first   = '0;
                n_seen    = '0;
            end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                if (r_phase == PH_FLAGS) begin
                    n_shift = {r_shift[15:0], in_byte};
                    if (r_pos >= 2'd2) begin
                        n_flags = {r_shift[15:0], in_byte};
                        n_pos   = 2'd0;
                        n_shift = '0;
                        n_phase = PH_COUNT;
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end else if (r_pos != 2'd3) begin
                    n_shift = {r_shift[15:0], in_byte};
                    n_pos   = r_pos + 2'd1;
                end else begin
                    // The byte completes a 32-bit word.
                    n_pos   = 2'd0;
                    n_shift = '0;
                    case (r_phase)
                        PH_COUNT: begin
                            n_count = word;
                            if ((r_flags & trp_pkg::FLAG_OFFSET) != '0) begin
                                n_phase = PH_OFFSET;
                            end else if ((r_flags & trp_pkg::FLAG_FIRST) != '0) begin
                                n_phase = PH_FIRST;
                            end else begin
                                hdr_done = 1'b1;
                            end
                        end
                        PH_OFFSET: begin
                            n_offset = word;
                            if ((r_flags & trp_pkg::FLAG_FIRST) != '0) begin
                                n_phase = PH_FIRST;
                            end else begin
                                hdr_done = 1'b1;
                            end
                        end
                        PH_FIRST: begin
                            n_first  = word;
                            hdr_done = 1'b1;
                        end
                        default: begin
                            if (k < 3'd3) begin
                                n_store[k[1:0]] = word;
                            end
                            nxt = next_field(r_flags, k + 3'd1);
                            if (nxt < 3'd4) begin
                                n_phase = phase_of(nxt);
                            end else begin
                                smp_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end

        if (hdr_done) begin
            // The header is last when the box declares no sample fields or no samples.
            rec_last = ((r_flags & trp_pkg::FLAG_ANY_SAMPLE) == '0) || (n_count == '0);
            n_seen   = '0;
            n_phase  = rec_last ? PH_DONE : phase_of(next_field(r_flags, 3'd0));
        end else if (smp_done) begin
            rec_last = (r_seen == r_count - 32'd1);
            n_seen   = r_seen + 32'd1;
            n_phase  = rec_last ? PH_DONE : phase_of(next_field(r_flags, 3'd0));
        end
    end

    // Record assembly. Sample fields completed earlier in the sample come from the
    // store; the field on this byte comes straight from the word.
    assign res_valid = hdr_done || smp_done;

    always_comb begin
        res                    = '0;
        res.record_kind        = smp_done ? trp_pkg::KIND_SAMPLE : trp_pkg::KIND_HEADER;
        res.box_version        = r_version;
        res.box_flags          = r_flags;
        res.count_of_samples   = n_count;
        res.payload_offset     = signed'(n_offset);
        res.first_flags        = n_first;
        res.last_record        = rec_last;
        if (smp_done) begin
            res.sample_number = r_seen;
            if ((r_flags & trp_pkg::FLAG_DURATION) != '0) begin
                res.duration = (k == 3'd0) ? word : r_store[0];
            end
            if ((r_flags & trp_pkg::FLAG_SIZE) != '0) begin
                res.size_bytes = (k == 3'd1) ? word : r_store[1];
            end
            if ((r_flags & trp_pkg::FLAG_SFLAGS) != '0) begin
                res.per_sample_flags = (k == 3'd2) ? word : r_store[2];
            end
            if ((r_flags & trp_pkg::FLAG_CTO) != '0) begin
                res.composition_offset = word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    // Held box fields and the sample store carry no reset; a start byte, or for
    // the store the earlier fields of the same sample, sets them up before any
    // of them is read.
    always_ff @(posedge i_clk) begin
        r_shift   <= n_shift;
        r_version <= n_version;
        r_flags   <= n_flags;
        r_count   <= n_count;
        r_offset  <= n_offset;
        r_first   <= n_first;
        r_store   <= n_store;
        r_seen    <= n_seen;
    end

    trp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A start byte always leads to collecting the flag bytes.
    a_start_to_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.box_start) |=> (r_phase == PH_FLAGS && r_pos == 2'd0))
        else $error("start transaction did not begin a new box");

    // No word is half collected while the parser waits for a start.
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_DONE) |-> (r_pos == 2'd0))
        else $error("byte position nonzero outside a box");

    // A record is only produced by an accepted transaction that is not a start byte.
    a_record_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (accept && !i_in_data.box_start))
        else $error("record produced without a data transaction");

    // The final record of a box leaves the parser waiting for the next start.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && rec_last) |=> (r_phase == PH_DONE))
        else $error("parser still active after the final record");

endmodule
